// ===== rtl/core/tps_pkg.sv =====
package tps_pkg;

    // default store depth
    localparam int MAX_ITEMS_DEF = 1024;

    // element width
    localparam int VALUE_W = 32;

endpackage

// ===== rtl/core/tps_in_if.sv =====
interface tps_in_if import tps_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      last;

    modport source (output valid, value, last, input ready);
    modport sink   (input valid, value, last, output ready);
endinterface

// ===== rtl/core/tps_out_if.sv =====
interface tps_out_if import tps_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] low_pivot;
    logic signed [VALUE_W-1:0] high_pivot;
    logic                      overflow;

    modport source (output valid, low_pivot, high_pivot, overflow, input ready);
    modport sink   (input valid, low_pivot, high_pivot, overflow, output ready);
endinterface

// ===== rtl/core/tps_store.sv =====
// Element store: one write port, one read port, registered read data.
module tps_store import tps_pkg::*; #(
    parameter int DEPTH = MAX_ITEMS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [VALUE_W-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [VALUE_W-1:0]         o_rd_data
);

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/tercile_pivot_selector.sv =====
// Channel | Dir | Payload                              | Beat
// --------+-----+--------------------------------------+-------------------------------
// i_in    | in  | value (s32), last                    | one element of the set
// o_out   | out | low_pivot (s32), high_pivot (s32),   | one result per set, after
//         |     | overflow                             | the beat with last set
//
// Load: one beat per cycle while collecting the set; beats past MAX_ITEMS
//   are dropped and flag overflow.
// After the last beat, i_in.ready stays low until the result is placed: the
//   exchange sort does one compare per cycle on the single comparator and the
//   single read port of the store, with read, hold and write-back steps per
//   outer pass, then the two pivots are read out.
// The result sits in an output register; a stalled o_out holds the block in
//   its final state until the register frees up, then loading resumes.
// Reset (i_rst_n low, synchronous) empties the set and drops any pending
//   result; the store contents are not cleared and need not be.

module tercile_pivot_selector import tps_pkg::*; #(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tps_in_if.sink    i_in,
    tps_out_if.source o_out
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_RD_I,
        S_LD_I,
        S_CMP,
        S_WR_I,
        S_RD_LO,
        S_RD_HI,
        S_PUT
    } t_state;

    t_state r_state, n_state;

    // load-side counters; n/3 tracked incrementally as quotient and remainder
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_q, n_q;
    logic [1:0]    r_r, n_r;
    logic          r_ovf, n_ovf;

    // snapshot of the closed set
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_nq, n_nq;
    logic          r_set_ovf, n_set_ovf;

    // sort indices and held element of the outer pass
    logic [AW-1:0]              r_i, n_i;
    logic [AW-1:0]              r_j, n_j;
    logic signed [VALUE_W-1:0]  r_cur, n_cur;
    logic signed [VALUE_W-1:0]  r_low, n_low;

    // output register
    logic                       r_out_valid, n_out_valid;
    logic signed [VALUE_W-1:0]  r_out_low, n_out_low;
    logic signed [VALUE_W-1:0]  r_out_high, n_out_high;
    logic                       r_out_ovf, n_out_ovf;

    // store port
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [VALUE_W-1:0]         wr_data;
    logic [AW-1:0]              rd_addr;
    logic [VALUE_W-1:0]         rd_data;
    logic signed [VALUE_W-1:0]  rd_value;

    logic          in_ready;
    logic          in_accept;
    logic [CW-1:0] n_last_pos;
    logic [CW-1:0] lo_inc;
    logic [CW-1:0] lo_pos;
    logic [CW-1:0] hi_pos;
    logic          swap;

    tps_store #(
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_value  = $signed(rd_data);
    assign in_ready  = (r_state == S_LOAD);
    assign in_accept = i_in.valid && in_ready;

    // pivot positions: low = min(n/3 + 1, n - 1), high = n - n/3 - 1
    assign n_last_pos = r_n - CW'(1);
    assign lo_inc     = r_nq + CW'(1);
    assign lo_pos     = (lo_inc > n_last_pos) ? n_last_pos : lo_inc;
    assign hi_pos     = n_last_pos - r_nq;

    // the shared comparator
    assign swap = (r_cur > rd_value);

    always_comb begin
        logic [CW-1:0] v_count;
        logic [CW-1:0] v_q;
        logic [1:0]    v_r;
        logic          v_ovf;

        n_state     = r_state;
        n_count     = r_count;
        n_q         = r_q;
        n_r         = r_r;
        n_ovf       = r_ovf;
        n_n         = r_n;
        n_nq        = r_nq;
        n_set_ovf   = r_set_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_cur       = r_cur;
        n_low       = r_low;
        n_out_valid = r_out_valid;
        n_out_low   = r_out_low;
        n_out_high  = r_out_high;
        n_out_ovf   = r_out_ovf;

        wr_en   = 1'b0;
        wr_addr = r_count[AW-1:0];
        wr_data = i_in.value;
        rd_addr = r_i;

        v_count = r_count;
        v_q     = r_q;
        v_r     = r_r;
        v_ovf   = r_ovf;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_LOAD: begin
                if (in_accept) begin
                    if (r_count < CW'(MAX_ITEMS)) begin
                        wr_en   = 1'b1;
                        v_count = r_count + CW'(1);
                        if (r_r == 2'd2) begin
                            v_r = 2'd0;
                            v_q = r_q + CW'(1);
                        end else begin
                            v_r = r_r + 2'd1;
                        end
                    end else begin
                        v_ovf = 1'b1;
                    end
                    n_count = v_count;
                    n_q     = v_q;
                    n_r     = v_r;
                    n_ovf   = v_ovf;
                    if (i_in.last) begin
                        n_n       = v_count;
                        n_nq      = v_q;
                        n_set_ovf = v_ovf;
                        n_count   = '0;
                        n_q       = '0;
                        n_r       = 2'd0;
                        n_ovf     = 1'b0;
                        n_i       = '0;
                        // a single element needs no sort
                        n_state   = (v_count == CW'(1)) ? S_RD_LO : S_RD_I;
                    end
                end
            end
            S_RD_I: begin
                rd_addr = r_i;
                n_j     = r_i + AW'(1);
                n_state = S_LD_I;
            end
            S_LD_I: begin
                rd_addr = r_j;
                n_cur   = rd_value;
                n_state = S_CMP;
            end
            S_CMP: begin
                // read of j+1 overlaps the compare at j
                rd_addr = r_j + AW'(1);
                if (swap) begin
                    wr_en   = 1'b1;
                    wr_addr = r_j;
                    wr_data = r_cur;
                    n_cur   = rd_value;
                end
                n_j = r_j + AW'(1);
                if (CW'(r_j) == n_last_pos) begin
                    n_state = S_WR_I;
                end
            end
            S_WR_I: begin
                wr_en   = 1'b1;
                wr_addr = r_i;
                wr_data = r_cur;
                n_i     = r_i + AW'(1);
                n_state = (CW'(r_i) + CW'(1) == n_last_pos) ? S_RD_LO : S_RD_I;
            end
            S_RD_LO: begin
                rd_addr = lo_pos[AW-1:0];
                n_state = S_RD_HI;
            end
            S_RD_HI: begin
                rd_addr = hi_pos[AW-1:0];
                n_low   = rd_value;
                n_state = S_PUT;
            end
            S_PUT: begin
                rd_addr = hi_pos[AW-1:0];
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_low   = r_low;
                    n_out_high  = rd_value;
                    n_out_ovf   = r_set_ovf;
                    n_state     = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_nq       <= n_nq;
        r_set_ovf  <= n_set_ovf;
        r_i        <= n_i;
        r_j        <= n_j;
        r_cur      <= n_cur;
        r_low      <= n_low;
        r_out_low  <= n_out_low;
        r_out_high <= n_out_high;
        r_out_ovf  <= n_out_ovf;
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_q         <= '0;
            r_r         <= 2'd0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_q         <= n_q;
            r_r         <= n_r;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.low_pivot  = r_out_low;
    assign o_out.high_pivot = r_out_high;
    assign o_out.overflow   = r_out_ovf;

    // count never passes the store depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("element count exceeds store depth");

    // remainder of the running n/3 stays below 3
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_r != 2'd3)
        else $error("n/3 remainder out of range");

    // inner index stays inside the set during compares
    a_j_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (CW'(r_j) < r_n))
        else $error("compare index past end of set");

    // closing beat empties the load counters
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.last) |=> (r_count == '0 && !r_ovf && r_r == 2'd0))
        else $error("load counters not cleared after last beat");

    // a pending result is never overwritten
    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT && r_out_valid && !o_out.ready) |=> (r_state == S_PUT))
        else $error("result written over pending output");

endmodule

// ===== dv/tercile_pivot_selector_tb.sv =====
`timescale 1ns / 1ps

module tercile_pivot_selector_tb import tps_pkg::*; ();

    // Stimulus sizing
    localparam int ITEM_TARGET  = 1350;        // input beats over the whole run
    localparam int BIG_SET      = MAX_ITEMS_DEF + 2;  // one stored-past-full set
    localparam int HOLD_CYCLES  = 800;         // long o_out stall
    localparam int END_SETTLE   = 16;          // cycles watched after the last result
    // Worst quiet stretch: a full 1024-entry sort, with no beat moving.
    localparam int QUIET_LIMIT  = 2_000_000;

    localparam logic signed [VALUE_W-1:0] V_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] V_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_element_beat;

    typedef struct {
        logic signed [VALUE_W-1:0] low_pivot;
        logic signed [VALUE_W-1:0] high_pivot;
        logic                      overflow;
    } t_pivot_pair;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Local copies of every driven input, known from time zero
    logic                      drv_valid = 1'b0;
    logic signed [VALUE_W-1:0] drv_value = '0;
    logic                      drv_last  = 1'b0;
    logic                      sink_ready = 1'b0;

    tps_in_if  in_bus ();
    tps_out_if out_bus ();

    assign in_bus.valid  = drv_valid;
    assign in_bus.value  = drv_value;
    assign in_bus.last   = drv_last;
    assign out_bus.ready = sink_ready;

    tercile_pivot_selector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Beats waiting to go out, filled by the sequence below
    t_element_beat pending_elems[$];
    int            items_queued = 0;

    // calm: no idling on either side; hold requests counted against grants
    logic calm = 1'b0;
    int   holds_asked   = 0;
    int   holds_granted = 0;
    int   stall_left    = 0;

    // Predictor state: the open set kept in ascending order as beats land
    logic signed [VALUE_W-1:0] set_held[$];
    logic                      set_overflow = 1'b0;
    t_pivot_pair               pivots_due[$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // ------------------------------------------------------------------
    // Predictor. Each accepted beat is folded into the open set; a beat
    // with last closes the set and yields the pair of tercile pivots.
    // Past MAX_ITEMS_DEF held entries, values are dropped and flagged.
    // ------------------------------------------------------------------
    task automatic fold_element(input logic signed [VALUE_W-1:0] v, input logic lst);
        int          slot;
        int          n;
        int          lo_idx;
        int          hi_idx;
        t_pivot_pair want;
        if (set_held.size() < MAX_ITEMS_DEF) begin
            slot = 0;
            while (slot < set_held.size() && set_held[slot] <= v) slot++;
            set_held.insert(slot, v);
        end else begin
            set_overflow = 1'b1;
        end
        if (lst) begin
            n = set_held.size();
            // n/3+1 runs past the end for a lone element; pin it to the top
            lo_idx = n / 3 + 1;
            if (lo_idx > n - 1) lo_idx = n - 1;
            hi_idx = n - n / 3 - 1;
            want.low_pivot  = set_held[lo_idx];
            want.high_pivot = set_held[hi_idx];
            want.overflow   = set_overflow;
            pivots_due.push_back(want);
            set_held.delete();
            set_overflow = 1'b0;
        end
    endtask

    // Values lean toward the extremes and a narrow band so sets carry duplicates
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return V_MIN;
            1:       return V_MAX;
            2:       return $urandom_range(0, 1) ? '1 : '0;
            3, 4, 5: return $signed($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_element(input logic signed [VALUE_W-1:0] v, input logic lst);
        t_element_beat b;
        b.value = v;
        b.last  = lst;
        pending_elems.push_back(b);
        items_queued++;
    endtask

    task automatic queue_random_set(input int n);
        for (int k = 0; k < n; k++) push_element(pick_value(), k == n - 1);
    endtask

    // Waits until every queued beat is out and every set's result is back
    task automatic drain_all();
        while (pending_elems.size() != 0 || drv_valid || pivots_due.size() != 0)
            @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: i_in. A beat stays up until taken; a new one is offered
    // right behind it unless the sender idles this cycle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_element_beat nxt;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else if (!drv_valid || in_bus.ready) begin
            if (pending_elems.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
                nxt = pending_elems.pop_front();
                drv_valid <= 1'b1;
                drv_value <= nxt.value;
                drv_last  <= nxt.last;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: o_out ready. A hold request turns into a long stall
    // counted here; otherwise ready drops at random unless calm.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sink_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            sink_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (holds_granted != holds_asked) begin
            sink_ready    <= 1'b0;
            stall_left    <= HOLD_CYCLES;
            holds_granted <= holds_granted + 1;
        end else begin
            sink_ready <= calm || ($urandom_range(0, 99) >= 33);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: accepted input beats feed the predictor, accepted result
    // beats are checked field by field against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pivot_pair want;
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready) fold_element(in_bus.value, in_bus.last);
            if (out_bus.valid && out_bus.ready) begin
                if (pivots_due.size() == 0) begin
                    $error("o_out: result beat with no pivots pending");
                    mismatch_count++;
                end else begin
                    want = pivots_due.pop_front();
                    if (out_bus.low_pivot !== want.low_pivot) begin
                        $error("low_pivot: expected %0d, got %0d",
                               want.low_pivot, out_bus.low_pivot);
                        mismatch_count++;
                    end
                    if (out_bus.high_pivot !== want.high_pivot) begin
                        $error("high_pivot: expected %0d, got %0d",
                               want.high_pivot, out_bus.high_pivot);
                        mismatch_count++;
                    end
                    if (out_bus.overflow !== want.overflow) begin
                        $error("overflow: expected %0b, got %0b",
                               want.overflow, out_bus.overflow);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no beat moving on either channel
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[tercile_pivot_selector] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence. Queue updates and flag changes happen at the falling
    // edge so the clocked processes never race them.
    // ------------------------------------------------------------------
    initial begin
        int n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: lone elements (pivot index clamped), extremes, duplicates
        push_element(32'sd5, 1'b1);
        push_element(V_MIN, 1'b1);
        push_element(V_MAX, 1'b1);
        push_element(V_MAX, 1'b0);
        push_element(V_MIN, 1'b1);
        push_element(-32'sd1, 1'b0);
        push_element(32'sd0, 1'b0);
        push_element(32'sd1, 1'b1);
        push_element(V_MAX, 1'b0);
        push_element(V_MIN, 1'b0);
        push_element(V_MIN, 1'b0);
        push_element(V_MAX, 1'b1);
        push_element(32'sd0, 1'b0);
        push_element(-32'sd1, 1'b0);
        push_element(V_MIN, 1'b0);
        push_element(V_MAX, 1'b0);
        push_element(32'sd1, 1'b1);
        // descending run of six
        for (int k = 6; k >= 1; k--) push_element(k * 1000 - 3000, k == 1);
        drain_all();

        // Store full: two beats past the depth, the closing one among the dropped.
        // Neither side idles through this long stretch.
        calm = 1'b1;
        queue_random_set(BIG_SET);
        drain_all();
        calm = 1'b0;

        // Long o_out stall while small sets keep coming: the output register
        // fills, the next set sorts, and i_in backs up.
        holds_asked = holds_asked + 1;
        for (int s = 0; s < 8; s++) queue_random_set($urandom_range(1, 5));
        drain_all();

        // Random sets, mostly short, now and then a few dozen deep
        while (items_queued < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) n = $urandom_range(13, 48);
            else                           n = $urandom_range(1, 12);
            queue_random_set(n);
        end
        drain_all();

        repeat (END_SETTLE) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[tercile_pivot_selector] OK");
        end else begin
            $display("[tercile_pivot_selector] ERROR");
        end
        $finish;
    end

endmodule
